// File: sv/object_word_relocation_emitter_macros.svh
// Assertion macros for the object word relocation emitter checker.
// Used by owre_checker; no other dependencies.
`ifndef OBJECT_WORD_RELOCATION_EMITTER_MACROS_SVH
`define OBJECT_WORD_RELOCATION_EMITTER_MACROS_SVH

// Same-cycle implication, clocked on i_clk, off during reset.
`define OWRE_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, clocked on i_clk, off during reset.
`define OWRE_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: sv/owre_pkg.sv
// Package for the object word relocation emitter: constants, codes and the
// word types passed between front, queue and back. No dependencies.
`timescale 1ns / 1ps

package owre_pkg;

    localparam int ADDR_BITS   = 16;
    localparam int DATA_W      = 16;
    localparam int QUEUE_DEPTH = 2;
    localparam int QUEUE_AW    = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int QUEUE_CW    = $clog2(QUEUE_DEPTH + 1);

    localparam logic [6:0]  EXTERNAL_TYPE   = 7'd32;
    localparam logic [4:0]  FIRST_BAD_CLASS = 5'd5;
    localparam logic [4:0]  EST_TEXT        = 5'd27;
    localparam logic [4:0]  EST_DATA        = 5'd28;
    localparam logic [15:0] ERR_COUNT_MAX   = 16'hFFFF;

    localparam logic [1:0] KIND_NONE  = 2'd0;
    localparam logic [1:0] KIND_WORD  = 2'd1;
    localparam logic [1:0] KIND_PATCH = 2'd2;

    localparam logic [1:0] ERR_NONE  = 2'd0;
    localparam logic [1:0] ERR_BSS   = 2'd1;
    localparam logic [1:0] ERR_ODD   = 2'd2;
    localparam logic [1:0] ERR_RELOC = 2'd3;

    localparam logic CFG_PASS = 1'b0;
    localparam logic CFG_BASE = 1'b1;

    typedef struct packed {
        logic        bss;
        logic        is_word;
        logic        byte_bad;
        logic        word_bad;
        logic        word_ext;
        logic        seg_sel;
        logic [15:0] tword;
        logic [15:0] rword;
        logic [7:0]  byte_val;
    } t_cmd;

    typedef struct packed {
        logic [1:0]  write_kind;
        logic [15:0] text_word;
        logic [15:0] reloc_word;
        logic [15:0] text_offset;
        logic [15:0] reloc_offset;
        logic [1:0]  error_code;
        logic [15:0] location;
        logic        nonexecutable;
        logic [15:0] error_count;
    } t_result;

endpackage

// File: sv/owre_front.sv
// Front end: classifies one input word and precomputes the relocated word
// and relocation word. Depends on owre_pkg.
`timescale 1ns / 1ps

module owre_front (
    input  logic                  i_action,
    input  logic [1:0]            i_segment,
    input  logic signed [6:0]     i_reloc_type,
    input  logic [15:0]           i_value,
    input  logic [13:0]           i_symbol_offset,
    input  logic [15:0]           i_base,
    output owre_pkg::t_cmd        o_cmd
);

    logic       neg;
    logic [6:0] mag;
    logic [4:0] cls;
    logic [4:0] cls_eff;
    logic [4:0] cls_out;
    logic       ext;

    assign neg = i_reloc_type[6];
    assign mag = neg ? (7'd0 - i_reloc_type) : i_reloc_type;
    assign cls = mag[4:0];
    assign ext = (mag == owre_pkg::EXTERNAL_TYPE);
    assign cls_eff = (cls >= owre_pkg::FIRST_BAD_CLASS) ? 5'd1 : cls;
    assign cls_out = (cls_eff == 5'd0) ? 5'd0 : cls_eff - 5'd1;

    always_comb begin
        o_cmd          = '0;
        o_cmd.bss      = i_segment[1];
        o_cmd.is_word  = i_action;
        o_cmd.seg_sel  = i_segment[0];
        o_cmd.byte_val = i_value[7:0];
        o_cmd.byte_bad = !neg && (i_reloc_type[5:0] > 6'd1);
        o_cmd.word_ext = ext;
        o_cmd.word_bad = !ext && ((cls == owre_pkg::EST_TEXT) || (cls == owre_pkg::EST_DATA));
        if (ext) begin
            o_cmd.tword = i_value;
            o_cmd.rword = {i_symbol_offset, 2'b00} | 16'h0008 | {15'd0, neg};
        end else begin
            // absolute-like classes move only on pc-relative use, others only when not
            if ((cls_eff < 5'd2) || (cls_eff > 5'd4)) begin
                o_cmd.tword = neg ? (i_value - i_base) : i_value;
            end else begin
                o_cmd.tword = neg ? i_value : (i_value + i_base);
            end
            o_cmd.rword = {10'd0, cls_out, neg};
        end
    end

endmodule

// File: sv/owre_queue.sv
// Short command queue between front and back ends.
// Depends on owre_pkg for depth and word type.
`timescale 1ns / 1ps

module owre_queue (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_push,
    input  owre_pkg::t_cmd          i_push_data,
    input  logic                    i_pop,
    output logic                    o_full,
    output logic                    o_empty,
    output owre_pkg::t_cmd          o_head
);

    owre_pkg::t_cmd                     r_mem [owre_pkg::QUEUE_DEPTH];
    logic [owre_pkg::QUEUE_AW-1:0]      r_wr;
    logic [owre_pkg::QUEUE_AW-1:0]      r_rd;
    logic [owre_pkg::QUEUE_CW-1:0]      r_count;
    logic [owre_pkg::QUEUE_AW-1:0]      n_wr;
    logic [owre_pkg::QUEUE_AW-1:0]      n_rd;
    logic [owre_pkg::QUEUE_CW-1:0]      n_count;

    localparam logic [owre_pkg::QUEUE_AW-1:0] LAST = owre_pkg::QUEUE_AW'(owre_pkg::QUEUE_DEPTH - 1);

    assign o_full  = (r_count == owre_pkg::QUEUE_CW'(owre_pkg::QUEUE_DEPTH));
    assign o_empty = (r_count == '0);
    assign o_head  = r_mem[r_rd];

    always_comb begin
        n_wr    = r_wr;
        n_rd    = r_rd;
        n_count = r_count;
        if (i_push) begin
            n_wr = (r_wr == LAST) ? '0 : r_wr + 1'b1;
        end
        if (i_pop) begin
            n_rd = (r_rd == LAST) ? '0 : r_rd + 1'b1;
        end
        if (i_push && !i_pop) begin
            n_count = r_count + 1'b1;
        end else if (!i_push && i_pop) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            r_wr    <= n_wr;
            r_rd    <= n_rd;
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_push_data;
        end
    end

endmodule

// File: sv/owre_back.sv
// Back end: holds location counters, output offsets, error count and the
// nonexecutable flag; takes one queued word per cycle unless stalled. Uses owre_pkg.
`timescale 1ns / 1ps

module owre_back (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cmd_valid,
    input  owre_pkg::t_cmd        i_cmd,
    input  logic [1:0]            i_pass,
    output logic                  o_pop,
    output logic                  o_valid,
    input  logic                  i_ready,
    output owre_pkg::t_result     o_res
);

    logic [owre_pkg::ADDR_BITS-1:0] r_loc  [2];
    logic [15:0]                    r_toff [2];
    logic [15:0]                    r_roff [2];
    logic [15:0]                    r_err;
    logic                           r_nx;
    logic                           r_valid;
    owre_pkg::t_result              r_res;

    logic [owre_pkg::ADDR_BITS-1:0] n_loc  [2];
    logic [15:0]                    n_toff [2];
    logic [15:0]                    n_roff [2];
    logic [15:0]                    n_err;
    logic                           n_nx;
    owre_pkg::t_result              n_res;

    logic                           s;
    logic                           pass2;
    logic                           as_byte;
    logic                           raise;
    logic                           set_nx;
    logic [owre_pkg::ADDR_BITS-1:0] loc;
    logic [owre_pkg::ADDR_BITS-1:0] loc_new;
    logic                           fire;

    assign fire    = i_cmd_valid && (!r_valid || i_ready);
    assign o_pop   = fire;
    assign o_valid = r_valid;
    assign o_res   = r_res;

    always_comb begin
        s       = i_cmd.seg_sel;
        pass2   = i_pass[1];
        loc     = r_loc[s];
        loc_new = loc;
        as_byte = 1'b0;
        raise   = 1'b0;
        set_nx  = 1'b0;
        n_loc   = r_loc;
        n_toff  = r_toff;
        n_roff  = r_roff;
        n_res   = '0;

        if (i_cmd.bss) begin
            n_res.error_code = owre_pkg::ERR_BSS;
            raise            = 1'b1;
        end else if (i_cmd.is_word) begin
            if (loc[0]) begin
                n_res.error_code = owre_pkg::ERR_ODD;
                raise            = 1'b1;
                as_byte          = 1'b1;
            end else begin
                loc_new = loc + owre_pkg::ADDR_BITS'(2);
                if (pass2) begin
                    set_nx = i_cmd.word_ext;
                    if (i_cmd.word_bad) begin
                        n_res.error_code = owre_pkg::ERR_RELOC;
                        raise            = 1'b1;
                    end
                    n_res.write_kind   = owre_pkg::KIND_WORD;
                    n_res.text_word    = i_cmd.tword;
                    n_res.reloc_word   = i_cmd.rword;
                    n_res.text_offset  = r_toff[s];
                    n_res.reloc_offset = r_roff[s];
                    n_toff[s]          = r_toff[s] + 16'd2;
                    n_roff[s]          = r_roff[s] + 16'd2;
                end
            end
        end else begin
            if (i_cmd.byte_bad) begin
                n_res.error_code = owre_pkg::ERR_RELOC;
                raise            = 1'b1;
            end
            as_byte = 1'b1;
        end

        if (as_byte) begin
            if (pass2) begin
                n_res.text_word = {8'd0, i_cmd.byte_val};
                if (!loc[0]) begin
                    n_res.write_kind   = owre_pkg::KIND_WORD;
                    n_res.text_offset  = r_toff[s];
                    n_res.reloc_offset = r_roff[s];
                    n_toff[s]          = r_toff[s] + 16'd2;
                    n_roff[s]          = r_roff[s] + 16'd2;
                end else begin
                    // high byte of the word written last
                    n_res.write_kind   = owre_pkg::KIND_PATCH;
                    n_res.text_offset  = r_toff[s] - 16'd2;
                    n_res.reloc_offset = r_roff[s] - 16'd2;
                end
            end
            loc_new = loc + owre_pkg::ADDR_BITS'(1);
        end

        if (!i_cmd.bss) begin
            n_loc[s] = loc_new;
        end

        n_err = (raise && (r_err != owre_pkg::ERR_COUNT_MAX)) ? r_err + 16'd1 : r_err;
        n_nx  = r_nx | raise | set_nx;

        // bss words leave the location counters unchanged and always report location zero
        n_res.location      = i_cmd.bss ? 16'd0 : loc_new[15:0];
        n_res.nonexecutable = n_nx;
        n_res.error_count   = n_err;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_loc   <= '{default: '0};
            r_toff  <= '{default: '0};
            r_roff  <= '{default: '0};
            r_err   <= '0;
            r_nx    <= 1'b0;
            r_valid <= 1'b0;
        end else if (fire) begin
            r_loc   <= n_loc;
            r_toff  <= n_toff;
            r_roff  <= n_roff;
            r_err   <= n_err;
            r_nx    <= n_nx;
            r_valid <= 1'b1;
        end else if (i_ready) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (fire) begin
            r_res <= n_res;
        end
    end

endmodule

// File: sv/object_word_relocation_emitter.sv
// Object word relocation emitter: top level joining front, queue and back.
// Depends on owre_pkg, owre_front, owre_queue, owre_back.
//
// Usage:
//   Input channel i_valid/o_ready carries one word per item: action (byte or
//   word), segment, signed relocation type, value and symbol offset.
//   Output channel o_valid/i_ready carries one result word per input word.
//   Configuration: i_cfg_we writes i_cfg_data to register i_cfg_index
//   (0 pass number, 1 relocation base) at the clock edge; write only while
//   the block is idle.
//   Path: an accepted word passes through the queue and then the output
//   register. Throughput: one word per cycle while the receiver does not stall;
//   the back end updates all its state as it takes a word and needs no idle gap.
//   A two-entry queue sits between the front decode and the back end; when
//   the receiver stalls, the output register holds and the queue fills, and
//   o_ready drops only when the queue is full.
//   Reset (synchronous, active low) clears counters, offsets, error count,
//   the nonexecutable flag, the queue and both configuration registers.
`timescale 1ns / 1ps

module object_word_relocation_emitter (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic                  i_cfg_index,
    input  logic [15:0]           i_cfg_data,
    input  logic                  i_valid,
    output logic                  o_ready,
    input  logic                  i_action,
    input  logic [1:0]            i_segment,
    input  logic signed [6:0]     i_reloc_type,
    input  logic [15:0]           i_value,
    input  logic [13:0]           i_symbol_offset,
    output logic                  o_valid,
    input  logic                  i_ready,
    output logic [1:0]            o_write_kind,
    output logic [15:0]           o_text_word,
    output logic [15:0]           o_reloc_word,
    output logic [15:0]           o_text_offset,
    output logic [15:0]           o_reloc_offset,
    output logic [1:0]            o_error_code,
    output logic [15:0]           o_location,
    output logic                  o_nonexecutable,
    output logic [15:0]           o_error_count
);

    logic [1:0]        r_pass;
    logic [15:0]       r_base;
    owre_pkg::t_cmd    front_cmd;
    owre_pkg::t_cmd    head_cmd;
    owre_pkg::t_result res;
    logic              q_full;
    logic              q_empty;
    logic              pop;
    logic              push;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pass <= '0;
            r_base <= '0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                owre_pkg::CFG_PASS: r_pass <= i_cfg_data[1:0];
                owre_pkg::CFG_BASE: r_base <= i_cfg_data;
            endcase
        end
    end

    assign o_ready = !q_full;
    assign push    = i_valid && !q_full;

    owre_front u_front (
        .i_action        (i_action),
        .i_segment       (i_segment),
        .i_reloc_type    (i_reloc_type),
        .i_value         (i_value),
        .i_symbol_offset (i_symbol_offset),
        .i_base          (r_base),
        .o_cmd           (front_cmd)
    );

    owre_queue u_queue (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (push),
        .i_push_data (front_cmd),
        .i_pop       (pop),
        .o_full      (q_full),
        .o_empty     (q_empty),
        .o_head      (head_cmd)
    );

    owre_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd_valid (!q_empty),
        .i_cmd       (head_cmd),
        .i_pass      (r_pass),
        .o_pop       (pop),
        .o_valid     (o_valid),
        .i_ready     (i_ready),
        .o_res       (res)
    );

    assign o_write_kind    = res.write_kind;
    assign o_text_word     = res.text_word;
    assign o_reloc_word    = res.reloc_word;
    assign o_text_offset   = res.text_offset;
    assign o_reloc_offset  = res.reloc_offset;
    assign o_error_code    = res.error_code;
    assign o_location      = res.location;
    assign o_nonexecutable = res.nonexecutable;
    assign o_error_count   = res.error_count;

endmodule

// File: sv/owre_checker.sv
// Port-level checker for object_word_relocation_emitter, bound to the top.
// Depends on owre_pkg and object_word_relocation_emitter_macros.svh.
`timescale 1ns / 1ps
`include "object_word_relocation_emitter_macros.svh"

module owre_checker (
    input logic                  i_clk,
    input logic                  i_rst_n,
    input logic                  o_valid,
    input logic                  i_ready,
    input logic [1:0]            o_write_kind,
    input logic [15:0]           o_text_word,
    input logic [15:0]           o_reloc_word,
    input logic [15:0]           o_text_offset,
    input logic [15:0]           o_reloc_offset,
    input logic [1:0]            o_error_code,
    input logic [15:0]           o_location,
    input logic                  o_nonexecutable,
    input logic [15:0]           o_error_count
);

    logic        stalled;
    logic [47:0] held_word;
    logic        none_seen;
    logic        none_clear;
    logic        err_seen;
    logic        err_flagged;
    logic        patch_seen;
    logic        patch_ok;
    logic        bss_seen;
    logic        bss_ok;

    assign stalled     = o_valid && !i_ready;
    assign held_word   = {o_text_word, o_location, o_error_count};
    assign none_seen   = o_valid && (o_write_kind == owre_pkg::KIND_NONE);
    assign none_clear  = (o_text_word == 16'd0) && (o_reloc_word == 16'd0) &&
                         (o_text_offset == 16'd0) && (o_reloc_offset == 16'd0);
    assign err_seen    = o_valid && (o_error_code != owre_pkg::ERR_NONE);
    assign err_flagged = o_nonexecutable && (o_error_count != 16'd0);
    assign patch_seen  = o_valid && (o_write_kind == owre_pkg::KIND_PATCH);
    assign patch_ok    = (o_reloc_word == 16'd0) && !o_location[0] &&
                         (o_text_word[15:8] == 8'd0);
    assign bss_seen    = o_valid && (o_error_code == owre_pkg::ERR_BSS);
    assign bss_ok      = (o_write_kind == owre_pkg::KIND_NONE) && (o_location == 16'd0);

    `OWRE_ASSERT_NEXT(a_out_hold, stalled, o_valid && $stable(held_word), "stalled output changed")

    `OWRE_ASSERT_NOW(a_none_zero, none_seen, none_clear, "unwritten result carries data")

    `OWRE_ASSERT_NOW(a_err_nonexec, err_seen, err_flagged, "error without flag or count")

    `OWRE_ASSERT_NOW(a_patch_shape, patch_seen, patch_ok, "byte patch malformed")

    `OWRE_ASSERT_NOW(a_bss_nowrite, bss_seen, bss_ok, "bss output wrote a word")

endmodule

bind object_word_relocation_emitter owre_checker u_owre_checker (.*);

// File: test/object_word_relocation_emitter_tb.sv
// Testbench for object_word_relocation_emitter: directed and random words checked
// against an in-bench predictor of the emitter state, with random stalls on both sides.
// Depends on owre_pkg and the object_word_relocation_emitter RTL.
`timescale 1ns / 1ps

module object_word_relocation_emitter_tb;

    localparam int unsigned CLASS_MASK = 31;
    localparam int unsigned CLASS_TEXT = 2;
    localparam int unsigned CLASS_BSS  = 4;
    localparam int unsigned EXT_FLAG   = 4;
    localparam int          HOLD_LONG  = 60;
    localparam int          DRAIN_MAX  = 5000;

    logic        i_clk = 1'b0;
    logic        i_rst_n;
    logic        i_cfg_we;
    logic        i_cfg_index;
    logic [15:0] i_cfg_data;
    logic        i_valid;
    logic        o_ready;
    logic        i_action;
    logic [1:0]  i_segment;
    logic signed [6:0] i_reloc_type;
    logic [15:0] i_value;
    logic [13:0] i_symbol_offset;
    logic        o_valid;
    logic        i_ready;
    logic [1:0]  o_write_kind;
    logic [15:0] o_text_word;
    logic [15:0] o_reloc_word;
    logic [15:0] o_text_offset;
    logic [15:0] o_reloc_offset;
    logic [1:0]  o_error_code;
    logic [15:0] o_location;
    logic        o_nonexecutable;
    logic [15:0] o_error_count;

    object_word_relocation_emitter u_top (.*);

    always #4 i_clk = ~i_clk;

    // emitter state as predicted
    logic [1:0]  cfg_pass;
    logic [15:0] cfg_base;
    logic [15:0] loc_ctr [0:2];
    logic [15:0] txt_off [0:1];
    logic [15:0] rel_off [0:1];
    logic [15:0] err_total;
    logic        nonexec;

    owre_pkg::t_result expected_results[$];
    owre_pkg::t_result check_want;
    int      fail_count;
    int      hold_request;
    int      sink_stall;
    bit      src_idle;
    bit      sink_idle;

    function automatic void bump_error();
        if (err_total != owre_pkg::ERR_COUNT_MAX)
            err_total++;
        nonexec = 1'b1;
    endfunction

    function automatic owre_pkg::t_result predict_emit(logic act, logic [1:0] seg_in,
                                                       logic signed [6:0] rtype,
                                                       logic [15:0] val, logic [13:0] sym);
        owre_pkg::t_result r;
        int          seg;
        logic        pass2;
        logic        neg;
        logic        as_byte;
        logic [6:0]  mag;
        int unsigned t;
        logic [15:0] v;
        r       = '0;
        pass2   = (cfg_pass >= 2);
        neg     = rtype[6];
        as_byte = 1'b0;
        seg     = seg_in;
        if (seg_in >= 2) begin
            seg = 2;
            r.error_code = owre_pkg::ERR_BSS;
            bump_error();
        end else if (act) begin
            if (loc_ctr[seg][0]) begin
                r.error_code = owre_pkg::ERR_ODD;
                bump_error();
                as_byte = 1'b1;
            end else begin
                loc_ctr[seg] = loc_ctr[seg] + 16'd2;
                if (pass2) begin
                    mag = neg ? 7'(-rtype) : rtype;
                    t   = mag;
                    v   = val;
                    if (t == owre_pkg::EXTERNAL_TYPE) begin
                        nonexec = 1'b1;
                        t = (int'(sym) << 1) | EXT_FLAG;
                    end else begin
                        t = t & CLASS_MASK;
                        if (t >= owre_pkg::FIRST_BAD_CLASS) begin
                            if (t == owre_pkg::EST_TEXT || t == owre_pkg::EST_DATA) begin
                                r.error_code = owre_pkg::ERR_RELOC;
                                bump_error();
                            end
                            t = 1;
                        end
                        // absolute adjusts only pc-relative, relocatable only direct
                        if (t < CLASS_TEXT || t > CLASS_BSS) begin
                            if (neg) v = v - cfg_base;
                        end else if (!neg) begin
                            v = v + cfg_base;
                        end
                        t = (t == 0) ? 0 : t - 1;
                    end
                    r.write_kind   = owre_pkg::KIND_WORD;
                    r.text_word    = v;
                    r.reloc_word   = 16'((t << 1) | neg);
                    r.text_offset  = txt_off[seg];
                    r.reloc_offset = rel_off[seg];
                    txt_off[seg]   = txt_off[seg] + 16'd2;
                    rel_off[seg]   = rel_off[seg] + 16'd2;
                end
            end
        end else begin
            if (rtype > 7'sd1) begin
                r.error_code = owre_pkg::ERR_RELOC;
                bump_error();
            end
            as_byte = 1'b1;
        end
        if (as_byte) begin
            if (pass2) begin
                r.text_word = {8'd0, val[7:0]};
                if (!loc_ctr[seg][0]) begin
                    r.write_kind   = owre_pkg::KIND_WORD;
                    r.text_offset  = txt_off[seg];
                    r.reloc_offset = rel_off[seg];
                    txt_off[seg]   = txt_off[seg] + 16'd2;
                    rel_off[seg]   = rel_off[seg] + 16'd2;
                end else begin
                    // high byte patch of the previous word
                    r.write_kind   = owre_pkg::KIND_PATCH;
                    r.text_offset  = txt_off[seg] - 16'd2;
                    r.reloc_offset = rel_off[seg] - 16'd2;
                end
            end
            loc_ctr[seg] = loc_ctr[seg] + 16'd1;
        end
        r.location      = loc_ctr[seg];
        r.nonexecutable = nonexec;
        r.error_count   = err_total;
        return r;
    endfunction

    function automatic int pick_gap();
        return ($urandom_range(0, 9) < 8) ? $urandom_range(1, 3) : $urandom_range(8, 20);
    endfunction

    function automatic int src_gap();
        if (!src_idle || $urandom_range(0, 9) < 6)
            return 0;
        return pick_gap();
    endfunction

    task automatic send_item(logic act, logic [1:0] seg, logic signed [6:0] rtype,
                             logic [15:0] val, logic [13:0] sym, int gap);
        i_valid         <= 1'b1;
        i_action        <= act;
        i_segment       <= seg;
        i_reloc_type    <= rtype;
        i_value         <= val;
        i_symbol_offset <= sym;
        @(posedge i_clk);
        while (!o_ready)
            @(posedge i_clk);
        expected_results.push_back(predict_emit(act, seg, rtype, val, sym));
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    task automatic drain_results();
        int waited;
        waited = 0;
        i_valid <= 1'b0;
        while (expected_results.size() != 0 && waited < DRAIN_MAX) begin
            @(posedge i_clk);
            waited++;
        end
        if (expected_results.size() != 0) begin
            $error("%0d expected words never arrived", expected_results.size());
            fail_count++;
            expected_results.delete();
        end
    endtask

    task automatic write_reg(logic idx, logic [15:0] data);
        drain_results();
        repeat (4) @(posedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        if (idx == owre_pkg::CFG_PASS)
            cfg_pass = data[1:0];
        else
            cfg_base = data;
    endtask

    // put the segment's location on an even address
    task automatic align_even(logic [1:0] seg);
        if (loc_ctr[seg][0])
            send_item(1'b0, seg, 7'sd0, 16'($urandom), 14'd0, src_gap());
    endtask

    task automatic send_random_item();
        logic              act;
        logic [1:0]        seg;
        logic signed [6:0] rtype;
        int                sel;
        act = ($urandom_range(0, 9) < 6);
        seg = ($urandom_range(0, 9) == 0) ? 2'($urandom_range(2, 3)) : 2'($urandom_range(0, 1));
        sel = $urandom_range(0, 7);
        if (sel < 4)
            rtype = act ? 7'($urandom_range(0, 4)) : 7'($urandom_range(0, 1));
        else if (sel == 4)
            rtype = 7'(owre_pkg::EXTERNAL_TYPE);
        else if (sel == 5)
            rtype = $urandom_range(0, 1) ? 7'(owre_pkg::EST_TEXT) : 7'(owre_pkg::EST_DATA);
        else
            rtype = 7'($urandom);
        if (sel < 6 && $urandom_range(0, 2) == 0)
            rtype = -rtype;
        send_item(act, seg, rtype, 16'($urandom), 14'($urandom), src_gap());
    endtask

    task automatic test_early_passes();
        send_item(1'b1, 2'd0, 7'sd1, 16'h1234, 14'd0, src_gap());
        send_item(1'b0, 2'd0, 7'sd0, 16'hABCD, 14'd0, src_gap());
        send_item(1'b1, 2'd0, 7'sd2, 16'h5555, 14'd0, src_gap());
        send_item(1'b0, 2'd1, 7'sd5, 16'h00FF, 14'd0, src_gap());
        send_item(1'b1, 2'd2, 7'sd1, 16'h0001, 14'd0, src_gap());
        send_item(1'b0, 2'd3, -7'sd1, 16'hFFFF, 14'd0, src_gap());
        write_reg(owre_pkg::CFG_PASS, 16'd1);
        send_item(1'b1, 2'd1, 7'sd0, 16'h0F0F, 14'd0, src_gap());
        send_item(1'b1, 2'd1, 7'sd32, 16'h8000, 14'h3FFF, src_gap());
    endtask

    task automatic test_pass_two_cases();
        write_reg(owre_pkg::CFG_PASS, 16'd2);
        write_reg(owre_pkg::CFG_BASE, 16'h1234);
        align_even(2'd0);
        send_item(1'b1, 2'd0, 7'sd0, 16'hFFFF, 14'd0, src_gap());
        send_item(1'b1, 2'd0, 7'sd1, 16'h0000, 14'd0, src_gap());
        send_item(1'b1, 2'd0, 7'sd2, 16'hFFFF, 14'd0, src_gap());
        send_item(1'b1, 2'd0, -7'sd3, 16'h0000, 14'd0, src_gap());
        send_item(1'b1, 2'd0, -7'sd1, 16'h0000, 14'd0, src_gap());
        send_item(1'b1, 2'd0, 7'sd32, 16'h1111, 14'h3FFF, src_gap());
        send_item(1'b1, 2'd0, -7'sd32, 16'h2222, 14'h0000, src_gap());
        send_item(1'b1, 2'd0, 7'(owre_pkg::EST_TEXT), 16'h3333, 14'd0, src_gap());
        send_item(1'b1, 2'd0, -7'(owre_pkg::EST_DATA), 16'h4444, 14'd0, src_gap());
        send_item(1'b1, 2'd0, 7'sd5, 16'h5555, 14'd0, src_gap());
        send_item(1'b1, 2'd0, 7'sd31, 16'h6666, 14'd0, src_gap());
        send_item(1'b1, 2'd0, 7'sd63, 16'h7777, 14'd0, src_gap());
        send_item(1'b1, 2'd0, -7'sd63, 16'h8888, 14'd0, src_gap());
        send_item(1'b1, 2'd0, -7'sd64, 16'h9999, 14'd0, src_gap());
        send_item(1'b0, 2'd0, 7'sd1, 16'h12FF, 14'd0, src_gap());
        send_item(1'b0, 2'd0, -7'sd1, 16'h3480, 14'd0, src_gap());
        send_item(1'b0, 2'd0, 7'sd2, 16'h5601, 14'd0, src_gap());
        send_item(1'b1, 2'd0, 7'sd1, 16'hBEEF, 14'd0, src_gap());
        align_even(2'd1);
        send_item(1'b1, 2'd1, 7'sd4, 16'h0010, 14'd0, src_gap());
        send_item(1'b1, 2'd1, 7'sd0, 16'h0000, 14'd0, src_gap());
        send_item(1'b1, 2'd2, 7'sd2, 16'hFFFF, 14'h3FFF, src_gap());
        send_item(1'b0, 2'd3, 7'sd0, 16'h00AA, 14'd0, src_gap());
    endtask

    task automatic send_random_item_b2b();
        bit saved;
        saved    = src_idle;
        src_idle = 1'b0;
        send_random_item();
        src_idle = saved;
    endtask

    // receiver holds off while the sender keeps offering back to back
    task automatic test_output_stall();
        drain_results();
        hold_request = HOLD_LONG;
        repeat (24) send_random_item_b2b();
        drain_results();
    endtask

    task automatic test_random_mix();
        for (int phase = 0; phase < 10; phase++) begin
            case (phase)
                0: begin
                    write_reg(owre_pkg::CFG_PASS, 16'd3);
                    write_reg(owre_pkg::CFG_BASE, 16'hFFFF);
                end
                1: begin
                    write_reg(owre_pkg::CFG_PASS, 16'd2);
                    write_reg(owre_pkg::CFG_BASE, 16'h0000);
                end
                2: begin
                    write_reg(owre_pkg::CFG_PASS, 16'd0);
                    write_reg(owre_pkg::CFG_BASE, 16'($urandom));
                end
                default: begin
                    write_reg(owre_pkg::CFG_PASS, ($urandom_range(0, 4) == 0) ?
                              16'($urandom_range(0, 1)) : 16'($urandom_range(2, 3)));
                    write_reg(owre_pkg::CFG_BASE, 16'($urandom));
                end
            endcase
            src_idle  = (phase % 4 != 1);
            sink_idle = (phase % 4 != 1);
            repeat (105) send_random_item();
        end
        src_idle  = 1'b1;
        sink_idle = 1'b1;
    endtask

    always begin : sink_proc
        @(posedge i_clk);
        if (hold_request != 0) begin
            sink_stall   = hold_request;
            hold_request = 0;
            i_ready <= 1'b0;
            repeat (sink_stall) @(posedge i_clk);
            i_ready <= 1'b1;
        end else if (sink_idle && $urandom_range(0, 3) == 0) begin
            sink_stall = pick_gap();
            i_ready <= 1'b0;
            repeat (sink_stall) @(posedge i_clk);
            i_ready <= 1'b1;
        end else begin
            i_ready <= 1'b1;
        end
    end

    task automatic check_field(string name, logic [15:0] want, logic [15:0] got);
        if (want !== got) begin
            $error("%s mismatch: expected %h, got %h", name, want, got);
            fail_count++;
        end
    endtask

    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && i_ready) begin
            if (expected_results.size() == 0) begin
                $error("result word with no expectation pending");
                fail_count++;
            end else begin
                check_want = expected_results.pop_front();
                check_field("write_kind", 16'(check_want.write_kind), 16'(o_write_kind));
                check_field("text_word", check_want.text_word, o_text_word);
                check_field("reloc_word", check_want.reloc_word, o_reloc_word);
                check_field("text_offset", check_want.text_offset, o_text_offset);
                check_field("reloc_offset", check_want.reloc_offset, o_reloc_offset);
                check_field("error_code", 16'(check_want.error_code), 16'(o_error_code));
                check_field("location", check_want.location, o_location);
                check_field("nonexecutable", 16'(check_want.nonexecutable),
                            16'(o_nonexecutable));
                check_field("error_count", check_want.error_count, o_error_count);
            end
        end
    end

    initial begin
        #2000000;
        $display("Simulation FAILED");
        $finish;
    end

    initial begin
        i_rst_n         = 1'b0;
        i_cfg_we        = 1'b0;
        i_cfg_index     = owre_pkg::CFG_PASS;
        i_cfg_data      = 16'd0;
        i_valid         = 1'b0;
        i_action        = 1'b0;
        i_segment       = 2'd0;
        i_reloc_type    = 7'sd0;
        i_value         = 16'd0;
        i_symbol_offset = 14'd0;
        i_ready         = 1'b0;
        cfg_pass        = 2'd0;
        cfg_base        = 16'd0;
        for (int i = 0; i < 3; i++)
            loc_ctr[i] = 16'd0;
        for (int i = 0; i < 2; i++) begin
            txt_off[i] = 16'd0;
            rel_off[i] = 16'd0;
        end
        err_total    = 16'd0;
        nonexec      = 1'b0;
        fail_count   = 0;
        hold_request = 0;
        src_idle     = 1'b1;
        sink_idle    = 1'b1;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        test_early_passes();
        test_pass_two_cases();
        test_output_stall();
        test_random_mix();
        drain_results();
        repeat (10) @(posedge i_clk);
        if (fail_count == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule
